// ===== rtl/core/svkc_pkg.sv =====
package svkc_pkg;

    localparam int unsigned Q_SHIFT    = 24;
    localparam int unsigned MU_SHIFT   = 8;
    localparam int unsigned LAM_SHIFT  = 9;
    localparam int unsigned JINV_SHIFT = 38;
    localparam int unsigned DIV_BITS   = 63;
    localparam int unsigned NUM_SLOTS  = 4;

    localparam logic signed [63:0] ONE_Q    = 64'sh0000_0000_0100_0000;
    localparam logic [62:0]        JINV_NUM = 63'h4000_0000_0000_0000;
    localparam logic signed [63:0] S64_MAX  = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_DET = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    // low bit of the register index picks mu or lambda of a slot
    localparam logic REG_KIND_MU     = 1'b0;
    localparam logic REG_KIND_LAMBDA = 1'b1;

    typedef struct packed {
        logic              sat;
        logic signed [63:0] val;
    } sat_sum_t;

    function automatic sat_sum_t sat_add(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
        logic signed [64:0] s;
        sat_sum_t r;
        s = {a[63], a} + {b[63], b};
        r.sat = (s[64] != s[63]);
        if (r.sat) begin
            r.val = s[64] ? S64_MIN : S64_MAX;
        end else begin
            r.val = s[63:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sext33(input logic signed [32:0] x);
        return {{31{x[32]}}, x};
    endfunction

    // displacement gradient entry recovered from a deformation gradient entry
    function automatic logic signed [63:0] h_of_f(input logic signed [32:0] f,
                                                  input logic diag);
        return sext33(f) - (diag ? ONE_Q : 64'sd0);
    endfunction

endpackage

// ===== rtl/core/svkc_mulsh.sv =====
module svkc_mulsh import svkc_pkg::*; #(
    parameter int unsigned SHIFT = Q_SHIFT
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] y,
    output logic               sat
);

    localparam logic [127:0] HALF = 128'(1) << (SHIFT - 1);

    logic [63:0]  ua_reg, ub_reg;
    logic         neg_a_reg, neg_b_reg, neg_c_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] acc_reg, acc_next;
    logic [127:0] rs;
    logic [63:0]  limit;
    logic         over;
    logic [63:0]  y_reg, y_next;
    logic         sat_reg;

    always_comb begin
        acc_next = {64'd0, p00_reg} + ({64'd0, p01_reg} << 32) + ({64'd0, p10_reg} << 32)
                 + {p11_reg, 64'd0} + HALF;
        rs       = acc_reg >> SHIFT;
        limit    = neg_c_reg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        over     = (|rs[127:64]) || (rs[63:0] > limit);
        if (over) begin
            y_next = neg_c_reg ? S64_MIN : S64_MAX;
        end else begin
            y_next = neg_c_reg ? (64'd0 - rs[63:0]) : rs[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ua_reg    <= a[63] ? (64'd0 - a) : a;
            ub_reg    <= b[63] ? (64'd0 - b) : b;
            neg_a_reg <= a[63] ^ b[63];
            p00_reg   <= ua_reg[31:0]  * ub_reg[31:0];
            p01_reg   <= ua_reg[31:0]  * ub_reg[63:32];
            p10_reg   <= ua_reg[63:32] * ub_reg[31:0];
            p11_reg   <= ua_reg[63:32] * ub_reg[63:32];
            neg_b_reg <= neg_a_reg;
            acc_reg   <= acc_next;
            neg_c_reg <= neg_b_reg;
            y_reg     <= y_next;
            sat_reg   <= over;
        end
    end

    assign y   = y_reg;
    assign sat = sat_reg;

endmodule

// ===== rtl/core/svkc_div.sv =====
module svkc_div import svkc_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  logic [62:0]         num,
    input  logic [63:0]         den,
    output logic [DIV_BITS-1:0] quo
);

    // restoring division, one quotient bit per stage; num and quotient share a shifter
    logic [62:0]         rem_reg [DIV_BITS];
    logic [63:0]         den_reg [DIV_BITS];
    logic [DIV_BITS-1:0] nq_reg  [DIV_BITS];

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
        logic [62:0]         rem_prev;
        logic [63:0]         den_prev;
        logic [DIV_BITS-1:0] nq_prev;
        logic [63:0]         trial;
        logic                ge;
        logic [63:0]         diff;

        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign den_prev = den;
            assign nq_prev  = num;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign nq_prev  = nq_reg[k-1];
        end

        assign trial = {rem_prev, nq_prev[DIV_BITS-1]};
        assign ge    = (trial >= den_prev);
        assign diff  = trial - den_prev;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[62:0] : trial[62:0];
                den_reg[k] <= den_prev;
                nq_reg[k]  <= {nq_prev[DIV_BITS-2:0], ge};
            end
        end
    end

    assign quo = nq_reg[DIV_BITS-1];

endmodule

// ===== rtl/core/svk_hyperelastic_cauchy_stress_core.sv =====
// St. Venant-Kirchhoff Cauchy stress core. Each transfer on the s_ side carries a 3x3
// displacement gradient (signed Q7.24) and a material slot; the m_ side returns the six
// Voigt components of the Cauchy stress (signed, 16 fraction bits, saturating) and a
// status (ok, non-positive det(F) with zeroed stresses, or saturated). The core is fully
// pipelined: it takes one item per cycle while m_ is not stalled. Its depth is set by the
// 63-stage quotient pipeline that forms 1/det(F) beside the stress datapath of 4-stage
// split 64-bit multipliers. A stall on m_ holds every stage. Material registers sit on
// the APB port: mu and lambda of slot n at 8n and 8n+4; write them only while no item is
// in flight.
module svk_hyperelastic_cauchy_stress_core import svkc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // grad_r1c1, grad_r2c1, grad_r3c1, grad_r1c2, grad_r2c2, grad_r3c2,
    // grad_r1c3, grad_r2c3, grad_r3c3
    input  logic [287:0] s_tdata,
    // material_slot
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // stress_11, stress_22, stress_33, stress_23, stress_13, stress_12
    output logic [383:0] m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned OUT_STAGE = 78;
    localparam int unsigned F_DEPTH   = 18;
    localparam int unsigned ML_DEPTH  = 7;
    localparam int unsigned DP_DEPTH  = 67;
    localparam int unsigned PD_DEPTH  = 50;

    // ---------------- configuration ----------------
    logic [31:0] mu_cfg_reg  [NUM_SLOTS];
    logic [31:0] lam_cfg_reg [NUM_SLOTS];
    logic [2:0]  cfg_idx;
    logic        cfg_wr;

    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < NUM_SLOTS; n++) begin
                mu_cfg_reg[n]  <= '0;
                lam_cfg_reg[n] <= '0;
            end
        end else if (cfg_wr) begin
            if (cfg_idx[0] == REG_KIND_LAMBDA) begin
                lam_cfg_reg[cfg_idx[2:1]] <= pwdata;
            end else begin
                mu_cfg_reg[cfg_idx[2:1]] <= pwdata;
            end
        end
    end

    always_comb begin
        if (cfg_idx[0] == REG_KIND_MU) begin
            prdata = mu_cfg_reg[cfg_idx[2:1]];
        end else begin
            prdata = lam_cfg_reg[cfg_idx[2:1]];
        end
    end

    // ---------------- pipeline control ----------------
    logic [OUT_STAGE:0] vld_reg;
    logic               en;

    assign en       = !vld_reg[OUT_STAGE] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[OUT_STAGE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[OUT_STAGE-1:0], s_tvalid};
        end
    end

    // ---------------- stage 0 and delay lines ----------------
    logic signed [32:0] f_pipe   [F_DEPTH][3][3];
    logic [31:0]        mu_pipe  [ML_DEPTH];
    logic [31:0]        lam_pipe [ML_DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    f_pipe[0][i][j] <= {s_tdata[(j*3+i)*32+31], s_tdata[(j*3+i)*32 +: 32]}
                                     + ((i == j) ? ONE_Q[32:0] : 33'sd0);
                end
            end
            mu_pipe[0]  <= mu_cfg_reg[s_tuser];
            lam_pipe[0] <= lam_cfg_reg[s_tuser];
            for (int k = 1; k < F_DEPTH; k++) begin
                f_pipe[k] <= f_pipe[k-1];
            end
            for (int k = 1; k < ML_DEPTH; k++) begin
                mu_pipe[k]  <= mu_pipe[k-1];
                lam_pipe[k] <= lam_pipe[k-1];
            end
        end
    end

    // saturation flags that land in each stage register
    logic [OUT_STAGE-1:0] flag_at;
    logic [OUT_STAGE-1:0] sat_pipe;

    // ---------------- determinant ----------------
    logic signed [63:0] mn_ax [3], mn_ay [3], mn_bx [3], mn_by [3];
    logic signed [63:0] mn_a [3], mn_b [3];
    logic               mn_a_sat [3], mn_b_sat [3];
    logic signed [63:0] minor_reg [3];
    logic signed [63:0] dp [3];
    logic               dp_sat [3];
    logic signed [63:0] det_reg;
    logic               det_pos;
    logic [DP_DEPTH-1:0] detpos_pipe;
    logic [62:0]        jinv;

    always_comb begin
        mn_ax[0] = sext33(f_pipe[0][1][1]); mn_ay[0] = sext33(f_pipe[0][2][2]);
        mn_bx[0] = sext33(f_pipe[0][1][2]); mn_by[0] = sext33(f_pipe[0][2][1]);
        mn_ax[1] = sext33(f_pipe[0][1][0]); mn_ay[1] = sext33(f_pipe[0][2][2]);
        mn_bx[1] = sext33(f_pipe[0][1][2]); mn_by[1] = sext33(f_pipe[0][2][0]);
        mn_ax[2] = sext33(f_pipe[0][1][0]); mn_ay[2] = sext33(f_pipe[0][2][1]);
        mn_bx[2] = sext33(f_pipe[0][1][1]); mn_by[2] = sext33(f_pipe[0][2][0]);
    end

    for (genvar c = 0; c < 3; c++) begin : g_det
        svkc_mulsh #(.SHIFT(Q_SHIFT)) u_mn_a (
            .aclk(aclk), .en(en), .a(mn_ax[c]), .b(mn_ay[c]), .y(mn_a[c]), .sat(mn_a_sat[c])
        );
        svkc_mulsh #(.SHIFT(Q_SHIFT)) u_mn_b (
            .aclk(aclk), .en(en), .a(mn_bx[c]), .b(mn_by[c]), .y(mn_b[c]), .sat(mn_b_sat[c])
        );
        svkc_mulsh #(.SHIFT(Q_SHIFT)) u_dp (
            .aclk(aclk), .en(en), .a(sext33(f_pipe[5][0][c])), .b(minor_reg[c]),
            .y(dp[c]), .sat(dp_sat[c])
        );
    end

    assign det_pos = !det_reg[63] && (det_reg != 64'sd0);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                minor_reg[c] <= mn_a[c] - mn_b[c];
            end
            det_reg     <= dp[0] - dp[1] + dp[2];
            detpos_pipe <= {detpos_pipe[DP_DEPTH-2:0], det_pos};
        end
    end

    svkc_div u_div (
        .aclk(aclk),
        .en  (en),
        .num (JINV_NUM + det_reg[63:1]),
        .den (det_reg),
        .quo (jinv)
    );

    // ---------------- strain and second Piola-Kirchhoff stress ----------------
    logic signed [63:0] gp [3][3][3];
    logic               gp_sat [3][3][3];
    logic signed [63:0] g_reg [3][3];
    logic signed [63:0] trg_reg;
    logic signed [63:0] sp [3][3];
    logic               sp_sat [3][3];
    logic signed [63:0] s_dly_reg [3][3];
    logic signed [63:0] lt;
    logic               lt_sat;
    logic signed [63:0] st_reg [3][3];
    logic               st_sat_reg;
    sat_sum_t           st_sum [3];

    for (genvar i = 0; i < 3; i++) begin : g_gi
        for (genvar j = 0; j < 3; j++) begin : g_gj
            for (genvar k = 0; k < 3; k++) begin : g_gk
                svkc_mulsh #(.SHIFT(Q_SHIFT)) u_gp (
                    .aclk(aclk), .en(en),
                    .a(h_of_f(f_pipe[0][k][i], k == i)),
                    .b(h_of_f(f_pipe[0][k][j], k == j)),
                    .y(gp[i][j][k]), .sat(gp_sat[i][j][k])
                );
            end
            svkc_mulsh #(.SHIFT(MU_SHIFT)) u_sp (
                .aclk(aclk), .en(en), .a({32'd0, mu_pipe[5]}), .b(g_reg[i][j]),
                .y(sp[i][j]), .sat(sp_sat[i][j])
            );
        end
    end

    svkc_mulsh #(.SHIFT(LAM_SHIFT)) u_lt (
        .aclk(aclk), .en(en), .a({32'd0, lam_pipe[6]}), .b(trg_reg), .y(lt), .sat(lt_sat)
    );

    always_comb begin
        for (int d = 0; d < 3; d++) begin
            st_sum[d] = sat_add(s_dly_reg[d][d], lt);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    g_reg[i][j] <= h_of_f(f_pipe[4][i][j], i == j)
                                 + h_of_f(f_pipe[4][j][i], i == j)
                                 + gp[i][j][0] + gp[i][j][1] + gp[i][j][2];
                    s_dly_reg[i][j] <= sp[i][j];
                    if (i == j) begin
                        st_reg[i][j] <= st_sum[i].val;
                    end else begin
                        st_reg[i][j] <= s_dly_reg[i][j];
                    end
                end
            end
            trg_reg    <= g_reg[0][0] + g_reg[1][1] + g_reg[2][2];
            st_sat_reg <= st_sum[0].sat || st_sum[1].sat || st_sum[2].sat;
        end
    end

    // ---------------- T = F S and P = T F^T ----------------
    logic signed [63:0] tp [3][3][3];
    logic               tp_sat [3][3][3];
    logic signed [63:0] t1_reg [3][3], tp2_reg [3][3], t_reg [3][3];
    logic signed [63:0] pp [3][3][3];
    logic               pp_sat [3][3][3];
    logic signed [63:0] p1_reg [3][3], pp2_reg [3][3], p_reg [3][3];
    logic               t1_sat_reg, t_sat_reg, p1_sat_reg, p_sat_reg;
    sat_sum_t           t1_sum [3][3], t_sum [3][3], p1_sum [3][3], p_sum [3][3];
    logic               t1_any, t_any, p1_any, p_any;

    for (genvar i = 0; i < 3; i++) begin : g_ti
        for (genvar j = 0; j < 3; j++) begin : g_tj
            for (genvar k = 0; k < 3; k++) begin : g_tk
                svkc_mulsh #(.SHIFT(Q_SHIFT)) u_tp (
                    .aclk(aclk), .en(en), .a(sext33(f_pipe[11][i][k])), .b(st_reg[k][j]),
                    .y(tp[i][j][k]), .sat(tp_sat[i][j][k])
                );
                svkc_mulsh #(.SHIFT(Q_SHIFT)) u_pp (
                    .aclk(aclk), .en(en), .a(t_reg[i][k]), .b(sext33(f_pipe[17][j][k])),
                    .y(pp[i][j][k]), .sat(pp_sat[i][j][k])
                );
            end
        end
    end

    always_comb begin
        t1_any = 1'b0;
        t_any  = 1'b0;
        p1_any = 1'b0;
        p_any  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                t1_sum[i][j] = sat_add(tp[i][j][0], tp[i][j][1]);
                t_sum[i][j]  = sat_add(t1_reg[i][j], tp2_reg[i][j]);
                p1_sum[i][j] = sat_add(pp[i][j][0], pp[i][j][1]);
                p_sum[i][j]  = sat_add(p1_reg[i][j], pp2_reg[i][j]);
                t1_any = t1_any | t1_sum[i][j].sat;
                t_any  = t_any  | t_sum[i][j].sat;
                p1_any = p1_any | p1_sum[i][j].sat;
                p_any  = p_any  | p_sum[i][j].sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    t1_reg[i][j]  <= t1_sum[i][j].val;
                    tp2_reg[i][j] <= tp[i][j][2];
                    t_reg[i][j]   <= t_sum[i][j].val;
                    p1_reg[i][j]  <= p1_sum[i][j].val;
                    pp2_reg[i][j] <= pp[i][j][2];
                    p_reg[i][j]   <= p_sum[i][j].val;
                end
            end
            t1_sat_reg <= t1_any;
            t_sat_reg  <= t_any;
            p1_sat_reg <= p1_any;
            p_sat_reg  <= p_any;
        end
    end

    // ---------------- wait for 1/det, then scale ----------------
    logic signed [63:0] pd_pipe [PD_DEPTH][3][3];
    logic signed [63:0] sg [3][3];
    logic               sg_sat [3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            pd_pipe[0] <= p_reg;
            for (int k = 1; k < PD_DEPTH; k++) begin
                pd_pipe[k] <= pd_pipe[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_si
        for (genvar j = 0; j < 3; j++) begin : g_sj
            svkc_mulsh #(.SHIFT(JINV_SHIFT)) u_sg (
                .aclk(aclk), .en(en), .a(pd_pipe[PD_DEPTH-1][i][j]), .b({1'b0, jinv}),
                .y(sg[i][j]), .sat(sg_sat[i][j])
            );
        end
    end

    // ---------------- saturation tracking ----------------
    always_comb begin
        flag_at     = '0;
        flag_at[4]  = mn_a_sat[0] | mn_a_sat[1] | mn_a_sat[2]
                    | mn_b_sat[0] | mn_b_sat[1] | mn_b_sat[2];
        flag_at[9]  = dp_sat[0] | dp_sat[1] | dp_sat[2];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                flag_at[9]  = flag_at[9] | sp_sat[i][j];
                flag_at[77] = flag_at[77] | sg_sat[i][j];
                for (int k = 0; k < 3; k++) begin
                    flag_at[4]  = flag_at[4]  | gp_sat[i][j][k];
                    flag_at[15] = flag_at[15] | tp_sat[i][j][k];
                    flag_at[21] = flag_at[21] | pp_sat[i][j][k];
                end
            end
        end
        flag_at[10] = lt_sat;
        flag_at[11] = st_sat_reg;
        flag_at[16] = t1_sat_reg;
        flag_at[17] = t_sat_reg;
        flag_at[22] = p1_sat_reg;
        flag_at[23] = p_sat_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_pipe <= {sat_pipe[OUT_STAGE-2:0] | flag_at[OUT_STAGE-2:0], 1'b0};
        end
    end

    // ---------------- output register ----------------
    logic [383:0] out_data_reg;
    logic [1:0]   out_status_reg;
    logic         pos_final, sat_final;

    assign pos_final = detpos_pipe[DP_DEPTH-1];
    assign sat_final = sat_pipe[OUT_STAGE-1] | flag_at[OUT_STAGE-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (pos_final) begin
                out_data_reg   <= {sg[0][1], sg[0][2], sg[1][2], sg[2][2], sg[1][1], sg[0][0]};
                out_status_reg <= sat_final ? STATUS_SAT : STATUS_OK;
            end else begin
                out_data_reg   <= '0;
                out_status_reg <= STATUS_DET;
            end
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_status_reg;

endmodule

// ===== tb/svkc_checker.sv =====
module svkc_checker import svkc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [383:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           fail_count,
    output int           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]   status;
        logic [383:0] stress;
    } stress_result_t;

    logic [31:0] mu_reg [NUM_SLOTS];
    logic [31:0] lam_reg [NUM_SLOTS];
    stress_result_t expected_stress_q [$];
    bit sat_flag;

    // rounded (halves away from zero), saturating a*b / 2^s
    function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int unsigned s);
        logic signed [127:0] p;
        logic [127:0] mag;
        logic signed [127:0] r;
        p = 128'(a) * 128'(b);
        mag = p[127] ? -p : p;
        mag = (mag + (128'd1 << (s - 1))) >> s;
        r = p[127] ? -$signed(mag) : $signed(mag);
        if (r > 128'(S64_MAX)) begin
            sat_flag = 1'b1;
            return S64_MAX;
        end
        if (r < 128'(S64_MIN)) begin
            sat_flag = 1'b1;
            return S64_MIN;
        end
        return r[63:0];
    endfunction

    function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_flag = 1'b1;
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic stress_result_t cauchy_stress(input logic [287:0] grad,
                                                     input logic [1:0] slot);
        logic signed [63:0] h [3][3];
        logic signed [63:0] f [3][3];
        logic signed [63:0] g [3][3];
        logic signed [63:0] sp [3][3];
        logic signed [63:0] t [3][3];
        logic signed [63:0] sg [3][3];
        logic signed [63:0] mu, lam, trg, lt, det, m0, m1, m2, p;
        logic [63:0] jinv;
        stress_result_t res;
        mu = {32'd0, mu_reg[slot]};
        lam = {32'd0, lam_reg[slot]};
        sat_flag = 1'b0;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++) begin
                h[r][c] = {{32{grad[(c*3+r)*32+31]}}, grad[(c*3+r)*32 +: 32]};
                f[r][c] = h[r][c] + ((r == c) ? ONE_Q : 64'sd0);
            end
        m0 = mul_round(f[1][1], f[2][2], Q_SHIFT) - mul_round(f[1][2], f[2][1], Q_SHIFT);
        m1 = mul_round(f[1][0], f[2][2], Q_SHIFT) - mul_round(f[1][2], f[2][0], Q_SHIFT);
        m2 = mul_round(f[1][0], f[2][1], Q_SHIFT) - mul_round(f[1][1], f[2][0], Q_SHIFT);
        det = mul_round(f[0][0], m0, Q_SHIFT) - mul_round(f[0][1], m1, Q_SHIFT)
            + mul_round(f[0][2], m2, Q_SHIFT);
        if (det <= 0) begin
            res.stress = '0;
            res.status = STATUS_DET;
            return res;
        end
        jinv = ((64'd1 << 62) + (64'(det) >> 1)) / 64'(det);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                g[i][j] = h[i][j] + h[j][i];
                for (int k = 0; k < 3; k++)
                    g[i][j] += mul_round(h[k][i], h[k][j], Q_SHIFT);
            end
        trg = g[0][0] + g[1][1] + g[2][2];
        lt = mul_round(lam, trg, LAM_SHIFT);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                sp[i][j] = mul_round(mu, g[i][j], MU_SHIFT);
                if (i == j)
                    sp[i][j] = add_clip(sp[i][j], lt);
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                t[i][j] = 0;
                for (int k = 0; k < 3; k++)
                    t[i][j] = add_clip(t[i][j], mul_round(f[i][k], sp[k][j], Q_SHIFT));
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                p = 0;
                for (int k = 0; k < 3; k++)
                    p = add_clip(p, mul_round(t[i][k], f[j][k], Q_SHIFT));
                sg[i][j] = mul_round(p, $signed(jinv), JINV_SHIFT);
            end
        res.stress = {sg[0][1], sg[0][2], sg[1][2], sg[2][2], sg[1][1], sg[0][0]};
        res.status = sat_flag ? STATUS_SAT : STATUS_OK;
        return res;
    endfunction

    always @(posedge aclk) begin
        stress_result_t want;
        if (!aresetn) begin
            for (int n = 0; n < NUM_SLOTS; n++) begin
                mu_reg[n] <= '0;
                lam_reg[n] <= '0;
            end
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[4:2] < 2 * NUM_SLOTS) begin
                if (paddr[2] == REG_KIND_MU)
                    mu_reg[paddr[4:3]] <= pwdata;
                else
                    lam_reg[paddr[4:3]] <= pwdata;
            end
            if (s_tvalid && s_tready)
                expected_stress_q.push_back(cauchy_stress(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                if (expected_stress_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transfer: %h %h", m_tuser, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_stress_q.pop_front();
                    if (want.stress !== m_tdata || want.status !== m_tuser) begin
                        if (fail_count < 10) begin
                            $display("mismatch status exp %0d got %0d", want.status, m_tuser);
                            for (int k = 0; k < 6; k++)
                                $display("  stress[%0d] exp %h got %h", k,
                                         want.stress[k*64 +: 64], m_tdata[k*64 +: 64]);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_stress_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
module tb import svkc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 78;
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [383:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending_count;
    int           cycle_count = 0;
    int           idle_pct = 28;
    bit           hold_sink = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    svk_hyperelastic_cauchy_stress_core i_dut (.*);

    svkc_checker i_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge aclk)
        m_tready <= !hold_sink && ($urandom_range(99) >= idle_pct);

    task automatic write_reg(input int idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_gradient(input logic [287:0] grad, input logic [1:0] slot);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= grad;
        s_tuser <= slot;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] grad_entry(input int mode, input bit diag);
        case (mode)
            0: return $urandom_range(2097152) - 1048576;
            1: return $urandom_range(33554432) - 16777216;
            2: return diag ? 32'($urandom_range(16777216) - 8388608) : $urandom_range(524288) - 262144;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [287:0] random_gradient(input int mode);
        logic [287:0] g;
        for (int e = 0; e < 9; e++)
            g[e*32 +: 32] = grad_entry(mode, e == 0 || e == 4 || e == 8);
        return g;
    endfunction

    function automatic logic [31:0] random_modulus(input int mode);
        case (mode)
            0: return $urandom_range(100000);
            1: return $urandom_range(1 << 20);
            default: return $urandom();
        endcase
    endfunction

    task automatic program_slots(input int mode);
        for (int r = 0; r < 2 * NUM_SLOTS; r++)
            write_reg(r, random_modulus(mode));
    endtask

    initial begin
        logic [287:0] g;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero moduli first: any well-formed gradient gives zero stress
        send_gradient('0, 2'd0);
        send_gradient(random_gradient(0), 2'd1);
        drain();

        write_reg(0, 32'd1000);
        write_reg(1, 32'd2000);
        write_reg(2, 32'hffff_ffff);
        write_reg(3, 32'hffff_ffff);
        write_reg(4, 32'd1);
        write_reg(5, 32'd0);
        write_reg(6, 32'd80000);
        write_reg(7, 32'd120000);

        for (int s = 0; s < 4; s++) begin
            send_gradient('0, 2'(s));
            send_gradient(random_gradient(0), 2'(s));
        end
        g = '0;
        g[0 +: 32] = -32'sd16777216;
        send_gradient(g, 2'd0);
        g[0 +: 32] = -32'sd33554432;
        send_gradient(g, 2'd3);
        send_gradient({9{32'h7fff_ffff}}, 2'd1);
        send_gradient({9{32'h8000_0000}}, 2'd2);
        g = '0;
        g[0 +: 32] = 32'h7fff_ffff;
        g[128 +: 32] = 32'h7fff_ffff;
        g[256 +: 32] = 32'h7fff_ffff;
        send_gradient(g, 2'd1);
        send_gradient(g, 2'd3);
        g[32 +: 32] = 32'h8000_0000;
        send_gradient(g, 2'd0);
        for (int k = 0; k < 6; k++)
            send_gradient(random_gradient(3), 2'($urandom_range(3)));
        drain();

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge aclk);
                hold_sink = 1'b0;
            end
            for (int k = 0; k < 120; k++)
                send_gradient(random_gradient(0), 2'($urandom_range(3)));
        join
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            program_slots(phase % 3);
            idle_pct = (phase == 2) ? 0 : 28;
            for (int k = 0; k < 110; k++)
                send_gradient(random_gradient($urandom_range(9) < 7 ?
                              $urandom_range(2) : 3), 2'($urandom_range(3)));
            drain();
        end

        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
